@@ hdl/efcd_pkg.sv @@
// efcd_pkg: shared types, constants and the step table of the flux block
`default_nettype none
package efcd_pkg;

	localparam int MAX_POINTS = 65536;
	localparam int INDEX_CAP_INT = ((MAX_POINTS - 1) < 65535) ? (MAX_POINTS - 1) : 65535;
	localparam logic [15:0] INDEX_CAP = 16'(INDEX_CAP_INT);

	localparam logic [31:0] GAMMA_RESET = 32'h3FB3_3333;
	localparam logic [31:0] F_ONE       = 32'h3F80_0000;
	localparam logic [31:0] F_HALF      = 32'h3F00_0000;
	localparam logic [31:0] F_QNAN      = 32'h7FC0_0000;

	typedef logic [1:0] fop_t;
	localparam fop_t FOP_ADD = 2'd0;
	localparam fop_t FOP_SUB = 2'd1;
	localparam fop_t FOP_MUL = 2'd2;
	localparam fop_t FOP_DIV = 2'd3;

	typedef logic [2:0] kind_t;
	localparam kind_t K_FOP       = 3'd0;
	localparam kind_t K_CHK_J     = 3'd1;
	localparam kind_t K_CHK_LAST  = 3'd2;
	localparam kind_t K_EMIT_MID  = 3'd3;
	localparam kind_t K_EMIT_WRAP = 3'd4;
	localparam kind_t K_EMIT_COPY = 3'd5;
	localparam kind_t K_DONE      = 3'd6;

	typedef logic [4:0] src_t;
	localparam src_t SRC_RHO  = 5'd0;
	localparam src_t SRC_MOM  = 5'd1;
	localparam src_t SRC_EN   = 5'd2;
	localparam src_t SRC_X    = 5'd3;
	localparam src_t SRC_GAM  = 5'd4;
	localparam src_t SRC_ONE  = 5'd5;
	localparam src_t SRC_HALF = 5'd6;
	localparam src_t SRC_T0   = 5'd7;
	localparam src_t SRC_T1   = 5'd8;
	localparam src_t SRC_T2   = 5'd9;
	localparam src_t SRC_T3   = 5'd10;
	localparam src_t SRC_T4   = 5'd11;
	localparam src_t SRC_T5   = 5'd12;
	localparam src_t SRC_NF1  = 5'd13;
	localparam src_t SRC_NF2  = 5'd14;
	localparam src_t SRC_FW00 = 5'd15;
	localparam src_t SRC_FW01 = 5'd16;
	localparam src_t SRC_FW02 = 5'd17;
	localparam src_t SRC_FW10 = 5'd18;
	localparam src_t SRC_FW11 = 5'd19;
	localparam src_t SRC_FW12 = 5'd20;
	localparam src_t SRC_FSP0 = 5'd21;
	localparam src_t SRC_FSP1 = 5'd22;
	localparam src_t SRC_FSP2 = 5'd23;
	localparam src_t SRC_PW0  = 5'd24;
	localparam src_t SRC_PW1  = 5'd25;
	localparam src_t SRC_PF0  = 5'd26;
	localparam src_t SRC_PF1  = 5'd27;

	typedef logic [3:0] dst_t;
	localparam dst_t DST_T0  = 4'd0;
	localparam dst_t DST_T1  = 4'd1;
	localparam dst_t DST_T2  = 4'd2;
	localparam dst_t DST_T3  = 4'd3;
	localparam dst_t DST_T4  = 4'd4;
	localparam dst_t DST_T5  = 4'd5;
	localparam dst_t DST_NF1 = 4'd6;
	localparam dst_t DST_NF2 = 4'd7;
	localparam dst_t DST_D0  = 4'd8;
	localparam dst_t DST_D1  = 4'd9;
	localparam dst_t DST_D2  = 4'd10;

	typedef logic [5:0] step_t;
	localparam step_t STEP_LAST = 6'd34;

	typedef struct packed {
		kind_t kind;
		fop_t  fop;
		src_t  src_a;
		src_t  src_b;
		logic  neg_a;
		dst_t  dst;
	} uop_t;

	typedef struct packed {
		logic  capture;
		logic  start;
		logic  write;
		logic  load_out;
		logic  update;
		kind_t kind;
		fop_t  fop;
		src_t  src_a;
		src_t  src_b;
		logic  neg_a;
		dst_t  dst;
	} cmd_t;

	typedef struct packed {
		logic fpu_done;
		logic j_ge2;
		logic last;
	} sts_t;

	function automatic uop_t mk(kind_t k, fop_t f, src_t a, src_t b, logic n, dst_t d);
		uop_t u;
		u.kind  = k;
		u.fop   = f;
		u.src_a = a;
		u.src_b = b;
		u.neg_a = n;
		u.dst   = d;
		return u;
	endfunction

	function automatic uop_t ctl(kind_t k);
		return mk(k, FOP_ADD, SRC_RHO, SRC_RHO, 1'b0, DST_T0);
	endfunction

	function automatic uop_t uop_at(step_t s);
		uop_t u;
		unique case (s)
			// pressure and fluxes of the new point
			6'd0:  u = mk(K_FOP, FOP_DIV, SRC_MOM,  SRC_RHO,  1'b0, DST_T0);
			6'd1:  u = mk(K_FOP, FOP_DIV, SRC_EN,   SRC_RHO,  1'b0, DST_T1);
			6'd2:  u = mk(K_FOP, FOP_SUB, SRC_GAM,  SRC_ONE,  1'b0, DST_T2);
			6'd3:  u = mk(K_FOP, FOP_MUL, SRC_T2,   SRC_RHO,  1'b0, DST_T2);
			6'd4:  u = mk(K_FOP, FOP_MUL, SRC_HALF, SRC_T0,   1'b0, DST_T3);
			6'd5:  u = mk(K_FOP, FOP_MUL, SRC_T3,   SRC_T0,   1'b0, DST_T3);
			6'd6:  u = mk(K_FOP, FOP_SUB, SRC_T1,   SRC_T3,   1'b0, DST_T3);
			6'd7:  u = mk(K_FOP, FOP_MUL, SRC_T2,   SRC_T3,   1'b0, DST_T2);
			6'd8:  u = mk(K_FOP, FOP_MUL, SRC_MOM,  SRC_T0,   1'b0, DST_T3);
			6'd9:  u = mk(K_FOP, FOP_ADD, SRC_T3,   SRC_T2,   1'b0, DST_NF1);
			6'd10: u = mk(K_FOP, FOP_ADD, SRC_EN,   SRC_T2,   1'b0, DST_T3);
			6'd11: u = mk(K_FOP, FOP_MUL, SRC_T0,   SRC_T3,   1'b0, DST_NF2);
			6'd12: u = ctl(K_CHK_J);
			// interior point j-1
			6'd13: u = mk(K_FOP, FOP_SUB, SRC_X,    SRC_PW1,  1'b0, DST_T4);
			6'd14: u = mk(K_FOP, FOP_DIV, SRC_ONE,  SRC_T4,   1'b0, DST_T4);
			6'd15: u = mk(K_FOP, FOP_SUB, SRC_MOM,  SRC_FW10, 1'b0, DST_T5);
			6'd16: u = mk(K_FOP, FOP_MUL, SRC_T5,   SRC_T4,   1'b1, DST_D0);
			6'd17: u = mk(K_FOP, FOP_SUB, SRC_NF1,  SRC_FW11, 1'b0, DST_T5);
			6'd18: u = mk(K_FOP, FOP_MUL, SRC_T5,   SRC_T4,   1'b1, DST_D1);
			6'd19: u = mk(K_FOP, FOP_SUB, SRC_NF2,  SRC_FW12, 1'b0, DST_T5);
			6'd20: u = mk(K_FOP, FOP_MUL, SRC_T5,   SRC_T4,   1'b1, DST_D2);
			6'd21: u = ctl(K_EMIT_MID);
			6'd22: u = ctl(K_CHK_LAST);
			// periodic wrap point
			6'd23: u = mk(K_FOP, FOP_SUB, SRC_X,    SRC_PW0,  1'b0, DST_T4);
			6'd24: u = mk(K_FOP, FOP_SUB, SRC_PF1,  SRC_PF0,  1'b0, DST_T5);
			6'd25: u = mk(K_FOP, FOP_ADD, SRC_T4,   SRC_T5,   1'b0, DST_T4);
			6'd26: u = mk(K_FOP, FOP_SUB, SRC_FSP0, SRC_FW00, 1'b0, DST_T5);
			6'd27: u = mk(K_FOP, FOP_DIV, SRC_T5,   SRC_T4,   1'b1, DST_D0);
			6'd28: u = mk(K_FOP, FOP_SUB, SRC_FSP1, SRC_FW01, 1'b0, DST_T5);
			6'd29: u = mk(K_FOP, FOP_DIV, SRC_T5,   SRC_T4,   1'b1, DST_D1);
			6'd30: u = mk(K_FOP, FOP_SUB, SRC_FSP2, SRC_FW02, 1'b0, DST_T5);
			6'd31: u = mk(K_FOP, FOP_DIV, SRC_T5,   SRC_T4,   1'b1, DST_D2);
			6'd32: u = ctl(K_EMIT_WRAP);
			6'd33: u = ctl(K_EMIT_COPY);
			default: u = ctl(K_DONE);
		endcase
		return u;
	endfunction

endpackage
`default_nettype wire

@@ hdl/efcd_fpu.sv @@
// efcd_fpu: shared single-precision add, subtract, multiply and iterative divide
`default_nettype none
module efcd_fpu (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire efcd_pkg::fop_t  op,
	input  wire logic [31:0]     a,
	input  wire logic [31:0]     b,
	output logic                 done,
	output logic [31:0]          result
);
	import efcd_pkg::*;

	localparam logic [2:0] F_IDLE   = 3'd0;
	localparam logic [2:0] F_PRE    = 3'd1;
	localparam logic [2:0] F_DIV    = 3'd2;
	localparam logic [2:0] F_NORM   = 3'd3;
	localparam logic [2:0] F_DENORM = 3'd4;
	localparam logic [2:0] F_ROUND  = 3'd5;

	logic [2:0]         st_q;
	logic               done_q;
	logic [31:0]        res_q;
	logic               sgn_q;
	logic signed [11:0] exp_q;
	logic [47:0]        r_q;
	logic [23:0]        ma_q, mb_q;
	logic signed [11:0] ea_q, eb_q;
	logic [25:0]        rem_q;
	logic [25:0]        quo_q;
	logic [4:0]         cnt_q;

	// operand unpack
	logic               sa, sb;
	logic [7:0]         fa, fb;
	logic [22:0]        ta, tb;
	logic               nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
	logic [23:0]        ma, mb;
	logic signed [11:0] ea, eb;

	assign sa = a[31];
	assign sb = b[31] ^ (op == FOP_SUB);
	assign fa = a[30:23];
	assign fb = b[30:23];
	assign ta = a[22:0];
	assign tb = b[22:0];
	assign nan_a  = (fa == 8'hFF) && (ta != 23'd0);
	assign nan_b  = (fb == 8'hFF) && (tb != 23'd0);
	assign inf_a  = (fa == 8'hFF) && (ta == 23'd0);
	assign inf_b  = (fb == 8'hFF) && (tb == 23'd0);
	assign zero_a = (fa == 8'd0) && (ta == 23'd0);
	assign zero_b = (fb == 8'd0) && (tb == 23'd0);
	assign ma = {fa != 8'd0, ta};
	assign mb = {fb != 8'd0, tb};
	assign ea = (fa == 8'd0) ? 12'sd1 : $signed({4'd0, fa});
	assign eb = (fb == 8'd0) ? 12'sd1 : $signed({4'd0, fb});

	// special operands
	logic        spec;
	logic [31:0] spec_res;

	always_comb begin
		spec     = 1'b0;
		spec_res = F_QNAN;
		case (op)
			FOP_ADD, FOP_SUB: begin
				if (nan_a || nan_b || (inf_a && inf_b && (sa != sb))) begin
					spec = 1'b1;
				end else if (inf_a) begin
					spec     = 1'b1;
					spec_res = {sa, 8'hFF, 23'd0};
				end else if (inf_b) begin
					spec     = 1'b1;
					spec_res = {sb, 8'hFF, 23'd0};
				end
			end
			FOP_MUL: begin
				if (nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b)) begin
					spec = 1'b1;
				end else if (inf_a || inf_b) begin
					spec     = 1'b1;
					spec_res = {sa ^ sb, 8'hFF, 23'd0};
				end else if (zero_a || zero_b) begin
					spec     = 1'b1;
					spec_res = {sa ^ sb, 31'd0};
				end
			end
			default: begin
				if (nan_a || nan_b || (zero_a && zero_b) || (inf_a && inf_b)) begin
					spec = 1'b1;
				end else if (inf_a || zero_b) begin
					spec     = 1'b1;
					spec_res = {sa ^ sb, 8'hFF, 23'd0};
				end else if (zero_a || inf_b) begin
					spec     = 1'b1;
					spec_res = {sa ^ sb, 31'd0};
				end
			end
		endcase
	end

	// add alignment
	logic               a_ge;
	logic [23:0]        mx, my;
	logic signed [11:0] ex, ey, dexp;
	logic               sx, sy;
	logic [5:0]         ash;
	logic [47:0]        ybig, yal, xal, asum;
	logic               ystk;

	always_comb begin
		a_ge = a[30:0] >= b[30:0];
		mx   = a_ge ? ma : mb;
		my   = a_ge ? mb : ma;
		ex   = a_ge ? ea : eb;
		ey   = a_ge ? eb : ea;
		sx   = a_ge ? sa : sb;
		sy   = a_ge ? sb : sa;
		dexp = ex - ey;
		ash  = (dexp > 12'sd48) ? 6'd48 : dexp[5:0];
		ybig = {1'b0, my, 23'd0};
		ystk = |(ybig & ~({48{1'b1}} << ash));
		yal  = (ybig >> ash) | {47'd0, ystk};
		xal  = {1'b0, mx, 23'd0};
		asum = (sx ^ sy) ? (xal - yal) : (xal + yal);
	end

	logic [47:0] mprod;
	assign mprod = ma * mb;

	// divide step
	logic        dge;
	logic [25:0] rem_sub, remn, qn;

	always_comb begin
		dge     = rem_q >= {2'd0, mb_q};
		rem_sub = dge ? (rem_q - {2'd0, mb_q}) : rem_q;
		remn    = {rem_sub[24:0], 1'b0};
		qn      = {quo_q[24:0], dge};
	end

	// subnormal shift
	logic signed [11:0] one_minus;
	logic [5:0]         dsh;
	logic [47:0]        rden;
	logic               dstk;

	always_comb begin
		one_minus = 12'sd1 - exp_q;
		dsh       = (one_minus > 12'sd48) ? 6'd48 : one_minus[5:0];
		dstk      = |(r_q & ~({48{1'b1}} << dsh));
		rden      = (r_q >> dsh) | {47'd0, dstk};
	end

	// round to nearest even
	logic [23:0]        mant, mant_f;
	logic [24:0]        m25;
	logic               up;
	logic signed [11:0] e2;
	logic [31:0]        rnd_res;

	always_comb begin
		mant   = r_q[46:23];
		up     = r_q[22] & ((|r_q[21:0]) | mant[0]);
		m25    = {1'b0, mant} + {24'd0, up};
		mant_f = m25[24] ? m25[24:1] : m25[23:0];
		e2     = exp_q + (m25[24] ? 12'sd1 : 12'sd0);
		if (e2 >= 12'sd255) begin
			rnd_res = {sgn_q, 8'hFF, 23'd0};
		end else begin
			rnd_res = {sgn_q, mant_f[23] ? e2[7:0] : 8'd0, mant_f[22:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= F_IDLE;
			done_q <= 1'b0;
			res_q  <= '0;
			sgn_q  <= 1'b0;
			exp_q  <= '0;
			r_q    <= '0;
			ma_q   <= '0;
			mb_q   <= '0;
			ea_q   <= '0;
			eb_q   <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				F_IDLE: begin
					if (start) begin
						if (spec) begin
							res_q  <= spec_res;
							done_q <= 1'b1;
						end else begin
							case (op)
								FOP_ADD, FOP_SUB: begin
									r_q   <= asum;
									exp_q <= ex;
									sgn_q <= (asum == 48'd0) ? (sx & sy) : sx;
									st_q  <= F_NORM;
								end
								FOP_MUL: begin
									r_q   <= mprod;
									exp_q <= ea + eb - 12'sd127;
									sgn_q <= sa ^ sb;
									st_q  <= F_NORM;
								end
								default: begin
									ma_q  <= ma;
									mb_q  <= mb;
									ea_q  <= ea;
									eb_q  <= eb;
									sgn_q <= sa ^ sb;
									st_q  <= F_PRE;
								end
							endcase
						end
					end
				end
				F_PRE: begin
					if (!ma_q[23]) begin
						ma_q <= {ma_q[22:0], 1'b0};
						ea_q <= ea_q - 12'sd1;
					end
					if (!mb_q[23]) begin
						mb_q <= {mb_q[22:0], 1'b0};
						eb_q <= eb_q - 12'sd1;
					end
					if (ma_q[23] && mb_q[23]) begin
						rem_q <= {2'd0, ma_q};
						quo_q <= '0;
						cnt_q <= '0;
						st_q  <= F_DIV;
					end
				end
				F_DIV: begin
					rem_q <= remn;
					quo_q <= qn;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd25) begin
						r_q   <= {1'b0, qn, 20'd0, remn != 26'd0};
						exp_q <= ea_q - eb_q + 12'sd127;
						st_q  <= F_NORM;
					end
				end
				F_NORM: begin
					if (r_q == 48'd0) begin
						res_q  <= {sgn_q, 31'd0};
						done_q <= 1'b1;
						st_q   <= F_IDLE;
					end else if (r_q[47]) begin
						r_q   <= {1'b0, r_q[47:2], r_q[1] | r_q[0]};
						exp_q <= exp_q + 12'sd1;
					end else if (!r_q[46]) begin
						if (r_q[47:39] == 9'd0) begin
							r_q   <= {r_q[39:0], 8'd0};
							exp_q <= exp_q - 12'sd8;
						end else begin
							r_q   <= {r_q[46:0], 1'b0};
							exp_q <= exp_q - 12'sd1;
						end
					end else begin
						st_q <= F_DENORM;
					end
				end
				F_DENORM: begin
					if (exp_q < 12'sd1) begin
						r_q   <= rden;
						exp_q <= 12'sd1;
					end
					st_q <= F_ROUND;
				end
				F_ROUND: begin
					res_q  <= rnd_res;
					done_q <= 1'b1;
					st_q   <= F_IDLE;
				end
				default: st_q <= F_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule
`default_nettype wire

@@ hdl/efcd_datapath.sv @@
// efcd_datapath: operand and window registers, the shared float unit and the output register
`default_nettype none
module efcd_datapath (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_write_en,
	input  wire logic [31:0]    cfg_write_data,
	input  wire logic [31:0]    density_bits,
	input  wire logic [31:0]    momentum_bits,
	input  wire logic [31:0]    energy_bits,
	input  wire logic [31:0]    position_bits,
	input  wire logic           last_point,
	input  wire efcd_pkg::cmd_t cmd,
	output efcd_pkg::sts_t      sts,
	output logic [15:0]         point_index,
	output logic [31:0]         d_density_bits,
	output logic [31:0]         d_momentum_bits,
	output logic [31:0]         d_energy_bits,
	output logic                last_result
);
	import efcd_pkg::*;

	logic [31:0] gam_q;
	logic [15:0] count_q;
	logic [31:0] rho_q, mom_q, en_q, x_q;
	logic        last_q;
	logic [31:0] t0_q, t1_q, t2_q, t3_q, t4_q, t5_q;
	logic [31:0] nf1_q, nf2_q;
	logic [31:0] d0_q, d1_q, d2_q;
	logic [31:0] fw00_q, fw01_q, fw02_q, fw10_q, fw11_q, fw12_q;
	logic [31:0] fsp0_q, fsp1_q, fsp2_q;
	logic [31:0] pw0_q, pw1_q, pf0_q, pf1_q;
	logic [15:0] idx_q;
	logic [31:0] od0_q, od1_q, od2_q;
	logic        olast_q;

	logic [31:0] srcv [32];
	logic [31:0] opa, opb, opa_n, fres;
	logic        fdone;

	always_comb begin
		for (int i = 0; i < 32; i++) begin
			srcv[i] = '0;
		end
		srcv[SRC_RHO]  = rho_q;
		srcv[SRC_MOM]  = mom_q;
		srcv[SRC_EN]   = en_q;
		srcv[SRC_X]    = x_q;
		srcv[SRC_GAM]  = gam_q;
		srcv[SRC_ONE]  = F_ONE;
		srcv[SRC_HALF] = F_HALF;
		srcv[SRC_T0]   = t0_q;
		srcv[SRC_T1]   = t1_q;
		srcv[SRC_T2]   = t2_q;
		srcv[SRC_T3]   = t3_q;
		srcv[SRC_T4]   = t4_q;
		srcv[SRC_T5]   = t5_q;
		srcv[SRC_NF1]  = nf1_q;
		srcv[SRC_NF2]  = nf2_q;
		srcv[SRC_FW00] = fw00_q;
		srcv[SRC_FW01] = fw01_q;
		srcv[SRC_FW02] = fw02_q;
		srcv[SRC_FW10] = fw10_q;
		srcv[SRC_FW11] = fw11_q;
		srcv[SRC_FW12] = fw12_q;
		srcv[SRC_FSP0] = fsp0_q;
		srcv[SRC_FSP1] = fsp1_q;
		srcv[SRC_FSP2] = fsp2_q;
		srcv[SRC_PW0]  = pw0_q;
		srcv[SRC_PW1]  = pw1_q;
		srcv[SRC_PF0]  = pf0_q;
		srcv[SRC_PF1]  = pf1_q;
	end

	assign opa   = srcv[cmd.src_a];
	assign opb   = srcv[cmd.src_b];
	assign opa_n = cmd.neg_a ? {~opa[31], opa[30:0]} : opa;

	efcd_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start),
		.op     (cmd.fop),
		.a      (opa_n),
		.b      (opb),
		.done   (fdone),
		.result (fres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gam_q   <= GAMMA_RESET;
			count_q <= '0;
		end else begin
			if (cfg_write_en) begin
				gam_q <= cfg_write_data;
			end
			if (cmd.update) begin
				if (last_q) begin
					count_q <= '0;
				end else if (count_q < INDEX_CAP) begin
					count_q <= count_q + 16'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rho_q  <= density_bits;
			mom_q  <= momentum_bits;
			en_q   <= energy_bits;
			x_q    <= position_bits;
			last_q <= last_point;
		end
		if (cmd.write) begin
			case (cmd.dst)
				DST_T0:  t0_q  <= fres;
				DST_T1:  t1_q  <= fres;
				DST_T2:  t2_q  <= fres;
				DST_T3:  t3_q  <= fres;
				DST_T4:  t4_q  <= fres;
				DST_T5:  t5_q  <= fres;
				DST_NF1: nf1_q <= fres;
				DST_NF2: nf2_q <= fres;
				DST_D0:  d0_q  <= fres;
				DST_D1:  d1_q  <= fres;
				DST_D2:  d2_q  <= fres;
				default: ;
			endcase
		end
		if (cmd.load_out) begin
			od0_q <= d0_q;
			od1_q <= d1_q;
			od2_q <= d2_q;
			case (cmd.kind)
				K_EMIT_MID: begin
					idx_q   <= count_q - 16'd1;
					olast_q <= 1'b0;
				end
				K_EMIT_WRAP: begin
					idx_q   <= '0;
					olast_q <= 1'b0;
				end
				default: begin
					idx_q   <= count_q;
					olast_q <= 1'b1;
				end
			endcase
		end
		if (cmd.update) begin
			fw10_q <= fw00_q;
			fw11_q <= fw01_q;
			fw12_q <= fw02_q;
			fw00_q <= mom_q;
			fw01_q <= nf1_q;
			fw02_q <= nf2_q;
			pw1_q  <= pw0_q;
			pw0_q  <= x_q;
			if (count_q == 16'd0) begin
				pf0_q <= x_q;
			end
			if (count_q == 16'd1) begin
				pf1_q  <= x_q;
				fsp0_q <= mom_q;
				fsp1_q <= nf1_q;
				fsp2_q <= nf2_q;
			end
		end
	end

	assign sts.fpu_done = fdone;
	assign sts.j_ge2    = count_q >= 16'd2;
	assign sts.last     = last_q;

	assign point_index     = idx_q;
	assign d_density_bits  = od0_q;
	assign d_momentum_bits = od1_q;
	assign d_energy_bits   = od2_q;
	assign last_result     = olast_q;

endmodule
`default_nettype wire

@@ hdl/efcd_ctrl.sv @@
// efcd_ctrl: sequencer that walks the step table and runs both handshakes
`default_nettype none
module efcd_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  wire logic           out_stall,
	output efcd_pkg::cmd_t      cmd,
	input  wire efcd_pkg::sts_t sts
);
	import efcd_pkg::*;

	localparam logic [2:0] C_IDLE   = 3'd0;
	localparam logic [2:0] C_ISSUE  = 3'd1;
	localparam logic [2:0] C_WAIT   = 3'd2;
	localparam logic [2:0] C_EMIT   = 3'd3;
	localparam logic [2:0] C_UPDATE = 3'd4;

	logic [2:0] state_q, state_d;
	step_t      step_q, step_d;
	logic       out_valid_q, out_valid_d;
	uop_t       u;
	logic       out_free;

	assign u        = uop_at(step_q);
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = state_q != C_IDLE;

	always_comb begin
		state_d      = state_q;
		step_d       = step_q;
		out_valid_d  = out_valid_q && out_stall;
		cmd.capture  = 1'b0;
		cmd.start    = 1'b0;
		cmd.write    = 1'b0;
		cmd.load_out = 1'b0;
		cmd.update   = 1'b0;
		cmd.kind     = u.kind;
		cmd.fop      = u.fop;
		cmd.src_a    = u.src_a;
		cmd.src_b    = u.src_b;
		cmd.neg_a    = u.neg_a;
		cmd.dst      = u.dst;
		unique case (state_q)
			C_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					step_d      = '0;
					state_d     = C_ISSUE;
				end
			end
			C_ISSUE: begin
				unique case (u.kind)
					K_FOP: begin
						cmd.start = 1'b1;
						state_d   = C_WAIT;
					end
					K_CHK_J: begin
						if (sts.j_ge2) step_d = step_q + 6'd1;
						else state_d = C_UPDATE;
					end
					K_CHK_LAST: begin
						if (sts.last) step_d = step_q + 6'd1;
						else state_d = C_UPDATE;
					end
					K_EMIT_MID, K_EMIT_WRAP, K_EMIT_COPY: state_d = C_EMIT;
					default: state_d = C_UPDATE;
				endcase
			end
			C_WAIT: begin
				if (sts.fpu_done) begin
					cmd.write = 1'b1;
					step_d    = step_q + 6'd1;
					state_d   = C_ISSUE;
				end
			end
			C_EMIT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					out_valid_d  = 1'b1;
					step_d       = step_q + 6'd1;
					state_d      = C_ISSUE;
				end
			end
			C_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = C_IDLE;
			end
			default: state_d = C_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= C_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			step_q      <= step_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_valid = out_valid_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.fpu_done |-> state_q == C_WAIT)
		else $error("float unit finished outside the wait state");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || !out_stall))
		else $error("output register overwritten while a request was pending");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == C_ISSUE && step_q == 6'd0))
		else $error("accepted request did not start the step sequence");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != C_IDLE |-> step_q <= STEP_LAST)
		else $error("step counter ran past the table");

endmodule
`default_nettype wire

@@ hdl/euler_flux_central_difference.sv @@
// euler_flux_central_difference: top level of the 1-d periodic euler right-hand-side block
// One request is one grid point (density, momentum, energy, position as single-precision
// words). All arithmetic runs on one shared float unit driven by a step sequencer. A divide
// is a 26-step restoring divider, run after subnormal operands are prenormalised. A new point
// is taken once the previous one is finished, while its last result may still sit in the
// output register. Results: point j gives the right-hand side of point j-1; the last point
// also gives point 0 and then point N-1 (a copy of point 0, with last_result set). Grids of
// fewer than three points give no results. Gamma (the heat ratio) is written through
// cfg_write_en / cfg_write_data and resets to 1.4; the user must write it only while the
// block is idle, which the block itself does not enforce.
`default_nettype none
module euler_flux_central_difference (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write_en,
	input  wire logic [31:0] cfg_write_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] density_bits,
	input  wire logic [31:0] momentum_bits,
	input  wire logic [31:0] energy_bits,
	input  wire logic [31:0] position_bits,
	input  wire logic        last_point,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      point_index,
	output logic [31:0]      d_density_bits,
	output logic [31:0]      d_momentum_bits,
	output logic [31:0]      d_energy_bits,
	output logic             last_result
);
	import efcd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	efcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	efcd_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write_en    (cfg_write_en),
		.cfg_write_data  (cfg_write_data),
		.density_bits    (density_bits),
		.momentum_bits   (momentum_bits),
		.energy_bits     (energy_bits),
		.position_bits   (position_bits),
		.last_point      (last_point),
		.cmd             (cmd),
		.sts             (sts),
		.point_index     (point_index),
		.d_density_bits  (d_density_bits),
		.d_momentum_bits (d_momentum_bits),
		.d_energy_bits   (d_energy_bits),
		.last_result     (last_result)
	);

endmodule
`default_nettype wire
